>>> hw/rtl/sdre_pkg.sv
package sdre_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_BEGIN = 3'd2,
    KIND_ROW   = 3'd3,
    KIND_END   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_SC_RD,
    ST_SC_CHK,
    ST_EX_RD,
    ST_EX_CHK,
    ST_EM_RD,
    ST_EM_CHK,
    ST_FLUSH,
    ST_ENDR
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [15:0] char_code;
    logic        use_cp437;
    logic [2:0]  fore_color;
    logic [2:0]  back_color;
    logic        is_bright;
  } in_word_t;

  typedef struct packed {
    logic        move_cursor;
    logic [4:0]  out_row;
    logic [6:0]  out_col;
    logic        set_attr;
    logic [2:0]  out_fore;
    logic [2:0]  out_back;
    logic        out_bright;
    logic [15:0] out_char;
    logic        has_char;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic        bright;
    logic [2:0]  back;
    logic [2:0]  fore;
    logic [15:0] ch;
  } cell_t;

  typedef logic [6:0] attr_t;

  localparam cell_t CELL_BLANK = '{bright: 1'b0, back: 3'd0, fore: 3'd7, ch: 16'h0020};

  localparam logic [15:0] CP437_LUT [256] = '{
    16'h0020, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
    16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h2302,
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

endpackage

>>> hw/rtl/screen_diff_run_emitter.sv
// Double-buffered character screen that emits only dirty runs of cells. A
// cell write stores a character, optionally mapped through the CP437 table,
// into the back store and moves the logical cursor past it. A row refresh
// scans both stores through one read port each and emits every character of
// each dirty same-attribute run, up to its last dirty cell, with cursor-move
// and attribute-change flags while syncing the front store; output stalls
// hold it. Clear and reset run a pass over all ROWS*COLS cells that blanks
// both stores to white-on-black spaces; no word is accepted during it. End
// of refresh emits one cursor-restore word when the physical cursor is off
// the logical one or unknown.
module screen_diff_run_emitter #(
  parameter int ROWS = 32,
  parameter int COLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdre_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdre_pkg::out_word_t out_word_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(COLS + 1);

  sdre_pkg::state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] c_q, c_d, start_q, start_d, end_q, end_d;
  sdre_pkg::attr_t attr_q, attr_d, emit_attr_q, emit_attr_d;
  logic emit_valid_q, emit_valid_d;
  logic phys_valid_q, phys_valid_d;
  logic [5:0] phys_row_q, phys_row_d, cur_row_q, cur_row_d, log_row_q, log_row_d;
  logic [CW-1:0] phys_col_q, phys_col_d, log_col_q, log_col_d;
  sdre_pkg::out_word_t pend_q, pend_d, out_q, out_new;
  logic pend_valid_q, pend_valid_d, out_valid_q, out_load, out_free;

  logic back_we, front_we;
  logic [AW-1:0] back_waddr, front_waddr, rd_addr, row_base;
  sdre_pkg::cell_t back_wdata, front_wdata, rd_back, rd_front, new_cell;
  logic [CW-1:0] c_rd;
  logic in_acc, end_need, first, dirty;
  sdre_pkg::out_word_t res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sdre_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign row_base = AW'(cur_row_q * COLS);
  assign c_rd     = (c_q < COLS) ? c_q : '0;
  assign rd_addr  = row_base + AW'(c_rd);
  assign dirty    = (rd_back != rd_front);
  assign first    = (c_q == start_q);
  assign end_need = !phys_valid_q || (phys_row_q != log_row_q) || (phys_col_q != log_col_q);

  always_comb begin
    new_cell.ch     = in_word_i.use_cp437 ? sdre_pkg::CP437_LUT[in_word_i.char_code[7:0]]
                                          : in_word_i.char_code;
    new_cell.fore   = in_word_i.fore_color;
    new_cell.back   = in_word_i.back_color;
    new_cell.bright = in_word_i.is_bright;
  end

  always_comb begin
    res.move_cursor = first && (!phys_valid_q || (phys_row_q != cur_row_q)
                                || (phys_col_q != c_q));
    res.out_row     = cur_row_q[4:0];
    res.out_col     = 7'(c_q);
    res.set_attr    = first && (!emit_valid_q || (emit_attr_q != attr_q));
    res.out_fore    = rd_back.fore;
    res.out_back    = rd_back.back;
    res.out_bright  = rd_back.bright;
    res.out_char    = rd_back.ch;
    res.has_char    = 1'b1;
    res.last_of_run = 1'b0;
  end

  sdre_cell_mem #(.Depth(CELLS), .Aw(AW)) u_back (
    .clk_i   (clk_i),
    .we_i    (back_we),
    .waddr_i (back_waddr),
    .wdata_i (back_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_back)
  );

  sdre_cell_mem #(.Depth(CELLS), .Aw(AW)) u_front (
    .clk_i   (clk_i),
    .we_i    (front_we),
    .waddr_i (front_waddr),
    .wdata_i (front_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_front)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdre_pkg::ST_CLR: begin
        if (clr_q == AW'(CELLS - 1)) state_d = sdre_pkg::ST_IDLE;
      end
      sdre_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_word_i.kind == sdre_pkg::KIND_CLEAR) begin
            state_d = sdre_pkg::ST_CLR;
          end else if (in_word_i.kind == sdre_pkg::KIND_ROW && in_word_i.row < ROWS) begin
            state_d = sdre_pkg::ST_SC_RD;
          end else if (in_word_i.kind == sdre_pkg::KIND_END) begin
            state_d = sdre_pkg::ST_ENDR;
          end
        end
      end
      sdre_pkg::ST_SC_RD: begin
        state_d = (c_q < COLS) ? sdre_pkg::ST_SC_CHK : sdre_pkg::ST_FLUSH;
      end
      sdre_pkg::ST_SC_CHK: begin
        state_d = dirty ? sdre_pkg::ST_EX_RD : sdre_pkg::ST_SC_RD;
      end
      sdre_pkg::ST_EX_RD: begin
        state_d = (c_q < COLS) ? sdre_pkg::ST_EX_CHK : sdre_pkg::ST_EM_RD;
      end
      sdre_pkg::ST_EX_CHK: begin
        state_d = ({rd_back.bright, rd_back.back, rd_back.fore} != attr_q)
                  ? sdre_pkg::ST_EM_RD : sdre_pkg::ST_EX_RD;
      end
      sdre_pkg::ST_EM_RD: begin
        state_d = sdre_pkg::ST_EM_CHK;
      end
      sdre_pkg::ST_EM_CHK: begin
        if (!pend_valid_q || out_free) begin
          state_d = (c_q == end_q) ? sdre_pkg::ST_SC_RD : sdre_pkg::ST_EM_RD;
        end
      end
      sdre_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = sdre_pkg::ST_IDLE;
      end
      sdre_pkg::ST_ENDR: begin
        if (!end_need || out_free) state_d = sdre_pkg::ST_IDLE;
      end
      default: state_d = sdre_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_d        = clr_q;
    c_d          = c_q;
    start_d      = start_q;
    end_d        = end_q;
    attr_d       = attr_q;
    emit_attr_d  = emit_attr_q;
    emit_valid_d = emit_valid_q;
    phys_valid_d = phys_valid_q;
    phys_row_d   = phys_row_q;
    phys_col_d   = phys_col_q;
    cur_row_d    = cur_row_q;
    log_row_d    = log_row_q;
    log_col_d    = log_col_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_load     = 1'b0;
    out_new      = pend_q;
    back_we      = 1'b0;
    back_waddr   = clr_q;
    back_wdata   = sdre_pkg::CELL_BLANK;
    front_we     = 1'b0;
    front_waddr  = clr_q;
    front_wdata  = sdre_pkg::CELL_BLANK;
    unique case (state_q)
      sdre_pkg::ST_CLR: begin
        back_we  = 1'b1;
        front_we = 1'b1;
        clr_d    = clr_q + AW'(1);
      end
      sdre_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority case (in_word_i.kind)
            sdre_pkg::KIND_WRITE: begin
              if (in_word_i.row < ROWS && in_word_i.col < COLS) begin
                back_we    = 1'b1;
                back_waddr = AW'(in_word_i.row * COLS) + AW'(in_word_i.col);
                back_wdata = new_cell;
                log_row_d  = in_word_i.row;
                log_col_d  = CW'(in_word_i.col) + CW'(1);
              end
            end
            sdre_pkg::KIND_CLEAR: begin
              clr_d        = '0;
              log_row_d    = '0;
              log_col_d    = '0;
              phys_valid_d = 1'b0;
              emit_valid_d = 1'b0;
            end
            sdre_pkg::KIND_BEGIN: begin
              phys_valid_d = 1'b0;
              emit_valid_d = 1'b0;
            end
            sdre_pkg::KIND_ROW: begin
              cur_row_d = in_word_i.row;
              c_d       = '0;
            end
            default: ;
          endcase
        end
      end
      sdre_pkg::ST_SC_RD: ;
      sdre_pkg::ST_SC_CHK: begin
        if (dirty) begin
          start_d = c_q;
          end_d   = c_q;
          attr_d  = {rd_back.bright, rd_back.back, rd_back.fore};
        end
        c_d = c_q + CW'(1);
      end
      sdre_pkg::ST_EX_RD: begin
        if (!(c_q < COLS)) c_d = start_q;
      end
      sdre_pkg::ST_EX_CHK: begin
        if ({rd_back.bright, rd_back.back, rd_back.fore} != attr_q) begin
          c_d = start_q;
        end else begin
          if (dirty) end_d = c_q;
          c_d = c_q + CW'(1);
        end
      end
      sdre_pkg::ST_EM_RD: ;
      sdre_pkg::ST_EM_CHK: begin
        if (!pend_valid_q || out_free) begin
          out_load     = pend_valid_q;
          pend_d       = res;
          pend_valid_d = 1'b1;
          front_we     = 1'b1;
          front_waddr  = rd_addr;
          front_wdata  = rd_back;
          if (first) begin
            emit_valid_d = 1'b1;
            emit_attr_d  = attr_q;
          end
          c_d = c_q + CW'(1);
          if (c_q == end_q) begin
            phys_valid_d = 1'b1;
            phys_row_d   = cur_row_q;
            phys_col_d   = c_q + CW'(1);
          end
        end
      end
      sdre_pkg::ST_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_load            = 1'b1;
          out_new.last_of_run = 1'b1;
          pend_valid_d        = 1'b0;
        end
      end
      sdre_pkg::ST_ENDR: begin
        if (end_need && out_free) begin
          out_load            = 1'b1;
          out_new             = '0;
          out_new.move_cursor = 1'b1;
          out_new.out_row     = log_row_q[4:0];
          out_new.out_col     = 7'(log_col_q);
          out_new.last_of_run = 1'b1;
          phys_valid_d        = 1'b1;
          phys_row_d          = log_row_q;
          phys_col_d          = log_col_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sdre_pkg::ST_CLR;
      clr_q        <= '0;
      emit_valid_q <= 1'b0;
      phys_valid_q <= 1'b0;
      log_row_q    <= '0;
      log_col_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      emit_valid_q <= emit_valid_d;
      phys_valid_q <= phys_valid_d;
      log_row_q    <= log_row_d;
      log_col_q    <= log_col_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q         <= c_d;
    start_q     <= start_d;
    end_q       <= end_d;
    attr_q      <= attr_d;
    emit_attr_q <= emit_attr_d;
    phys_row_q  <= phys_row_d;
    phys_col_q  <= phys_col_d;
    cur_row_q   <= cur_row_d;
    pend_q      <= pend_d;
    if (out_load) out_q <= out_new;
  end

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sdre_pkg::ST_IDLE |-> !pend_valid_q)
    else $error("pending word left at idle");

  a_restore_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.has_char |-> out_q.last_of_run && out_q.move_cursor)
    else $error("cursor restore word malformed");

  a_front_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_we |-> state_q == sdre_pkg::ST_EM_CHK || state_q == sdre_pkg::ST_CLR)
    else $error("front store written outside emit or clear");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("output word overwritten while stalled");

endmodule

>>> hw/rtl/sdre_cell_mem.sv
module sdre_cell_mem #(
  parameter int Depth = 2048,
  parameter int Aw    = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [Aw-1:0]     waddr_i,
  input  sdre_pkg::cell_t   wdata_i,
  input  logic [Aw-1:0]     raddr_i,
  output sdre_pkg::cell_t   rdata_o
);

  sdre_pkg::cell_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> tb/sv/tb_screen_diff_run_emitter.sv
module tb_screen_diff_run_emitter;

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [6:0] ATTR_WHITE = 7'h07;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  sdre_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sdre_pkg::out_word_t out_word_o;

  screen_diff_run_emitter #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // screen model
  sdre_pkg::cell_t     back_cells [ROWS*COLS];
  sdre_pkg::cell_t     front_cells [ROWS*COLS];
  logic                attr_ok;
  sdre_pkg::attr_t     attr_sent;
  logic                cur_ok;
  int                  cur_row, cur_col, log_row, log_col;
  sdre_pkg::out_word_t pending_words [$];
  int                  errors = 0;
  longint              cycles = 0;

  function automatic sdre_pkg::attr_t attr_of(sdre_pkg::cell_t c);
    return {c.bright, c.back, c.fore};
  endfunction

  function automatic sdre_pkg::out_word_t char_word(logic mv, int r, int c, logic sa,
                                                    sdre_pkg::cell_t cl);
    sdre_pkg::out_word_t w;
    w = '0;
    w.move_cursor = mv;
    w.out_row = r[4:0];
    w.out_col = c[6:0];
    w.set_attr = sa;
    w.out_fore = cl.fore;
    w.out_back = cl.back;
    w.out_bright = cl.bright;
    w.out_char = cl.ch;
    w.has_char = 1'b1;
    return w;
  endfunction

  task automatic blank_screen();
    for (int i = 0; i < ROWS*COLS; i++) begin
      back_cells[i] = sdre_pkg::CELL_BLANK;
      front_cells[i] = sdre_pkg::CELL_BLANK;
    end
  endtask

  task automatic scan_row(int r);
    int base, c, s, e, nc;
    sdre_pkg::attr_t a;
    logic mv, sa;
    base = r * COLS;
    c = 0;
    while (c < COLS) begin
      if (back_cells[base+c] == front_cells[base+c]) begin
        c++;
        continue;
      end
      s = c;
      a = attr_of(back_cells[base+c]);
      e = c;
      for (nc = c + 1; nc < COLS; nc++) begin
        if (attr_of(back_cells[base+nc]) != a) break;
        e = nc;
      end
      while (e > s && back_cells[base+e] == front_cells[base+e]) e--;
      for (int i = s; i <= e; i++) begin
        mv = 1'b0;
        sa = 1'b0;
        if (i == s) begin
          mv = !cur_ok || cur_row != r || cur_col != s;
          sa = !attr_ok || attr_sent != a;
          attr_ok = 1'b1;
          attr_sent = a;
        end
        pending_words.push_back(char_word(mv, r, i, sa, back_cells[base+i]));
        front_cells[base+i] = back_cells[base+i];
      end
      cur_ok = 1'b1;
      cur_row = r;
      cur_col = e + 1;
      c = e + 1;
    end
  endtask

  // appends expected words; returns their count
  task automatic predict_screen(sdre_pkg::in_word_t w, output int n);
    int prev_cnt;
    sdre_pkg::out_word_t rw;
    sdre_pkg::cell_t cl;
    prev_cnt = pending_words.size();
    case (w.kind)
      sdre_pkg::KIND_WRITE: if (w.row < ROWS && w.col < COLS) begin
        cl.ch = w.use_cp437 ? sdre_pkg::CP437_LUT[w.char_code[7:0]] : w.char_code;
        cl.fore = w.fore_color;
        cl.back = w.back_color;
        cl.bright = w.is_bright;
        back_cells[w.row*COLS + w.col] = cl;
        log_row = w.row;
        log_col = w.col + 1;
      end
      sdre_pkg::KIND_CLEAR: begin
        blank_screen();
        log_row = 0;
        log_col = 0;
        cur_ok = 1'b0;
        attr_ok = 1'b0;
      end
      sdre_pkg::KIND_BEGIN: begin
        cur_ok = 1'b0;
        attr_ok = 1'b0;
      end
      sdre_pkg::KIND_ROW: if (w.row < ROWS) scan_row(w.row);
      sdre_pkg::KIND_END: if (!cur_ok || cur_row != log_row || cur_col != log_col) begin
        rw = '0;
        rw.move_cursor = 1'b1;
        rw.out_row = log_row[4:0];
        rw.out_col = log_col[6:0];
        pending_words.push_back(rw);
        cur_ok = 1'b1;
        cur_row = log_row;
        cur_col = log_col;
      end
      default: ;
    endcase
    n = pending_words.size() - prev_cnt;
    if (n > 0) pending_words[pending_words.size()-1].last_of_run = 1'b1;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  int quiet_in = 0;

  // valid stays high into the next word when there is no gap
  task automatic send_word(sdre_pkg::in_word_t w);
    int n, g;
    g = quiet_in ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_word_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_screen(w, n);
    @(negedge clk_i);
  endtask

  function automatic sdre_pkg::in_word_t mk(sdre_pkg::kind_e k, int r, int c, int ch, int u,
                                            int f, int b, int br);
    sdre_pkg::in_word_t w;
    w.kind = k;
    w.row = r[5:0];
    w.col = c[6:0];
    w.char_code = ch[15:0];
    w.use_cp437 = u[0];
    w.fore_color = f[2:0];
    w.back_color = b[2:0];
    w.is_bright = br[0];
    return w;
  endfunction

  // directed table: stimulus, expected words only where obvious
  typedef struct {
    sdre_pkg::in_word_t  w;
    int                  n_fixed;
    sdre_pkg::out_word_t first;
  } dir_row_t;

  dir_row_t dir_tbl [$];
  int stall_mode = 0;

  task automatic add_row(sdre_pkg::in_word_t w, int n = -1, sdre_pkg::out_word_t f = '0);
    dir_row_t d;
    d.w = w;
    d.n_fixed = n;
    d.first = f;
    dir_tbl.push_back(d);
  endtask

  initial begin
    sdre_pkg::out_word_t restore0;
    restore0 = '0;
    restore0.move_cursor = 1'b1;
    restore0.last_of_run = 1'b1;
    add_row(mk(sdre_pkg::KIND_END, 0, 0, 0, 0, 0, 0, 0), 1, restore0);
    add_row(mk(sdre_pkg::KIND_END, 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_ROW, 5, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_WRITE, 0, 0, 16'hFFFF, 0, 7, 7, 1));
    add_row(mk(sdre_pkg::KIND_WRITE, 0, 1, 16'h0000, 0, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 0, 2, 16'h0000, 1, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 0, 3, 16'hFF7F, 1, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 0, 4, 16'h1280, 1, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 0, 5, 16'h00FF, 1, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 31, 63, 16'h0041, 0, 3, 5, 1));
    add_row(mk(sdre_pkg::KIND_WRITE, 32, 0, 16'h0041, 0, 1, 1, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 63, 127, 16'h0041, 0, 1, 1, 0));
    add_row(mk(sdre_pkg::KIND_WRITE, 2, 64, 16'h0041, 0, 1, 1, 0));
    add_row(mk(sdre_pkg::KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_ROW, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_ROW, 31, 0, 0, 0, 0, 0, 0));
    add_row(mk(sdre_pkg::KIND_ROW, 32, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_ROW, 63, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_END, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(sdre_pkg::kind_e'(3'd5), 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::kind_e'(3'd7), 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_WRITE, 31, 63, 16'h0042, 0, 7, 0, 0));
    add_row(mk(sdre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_ROW, 0, 0, 0, 0, 0, 0, 0), 0);
    add_row(mk(sdre_pkg::KIND_END, 0, 0, 0, 0, 0, 0, 0));
  end

  initial begin
    int n, prev_cnt, r, c;
    blank_screen();
    attr_ok = 1'b0;
    attr_sent = ATTR_WHITE;
    cur_ok = 1'b0;
    cur_row = 0;
    cur_col = 0;
    log_row = 0;
    log_col = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    quiet_in = 1;
    foreach (dir_tbl[i]) begin
      in_word_i <= dir_tbl[i].w;
      in_valid_i <= 1'b1;
      do @(posedge clk_i); while (in_stall_o);
      prev_cnt = pending_words.size();
      predict_screen(dir_tbl[i].w, n);
      if (dir_tbl[i].n_fixed >= 0 && n != dir_tbl[i].n_fixed) begin
        $display("%0t word count mismatch row %0d: expected %0d actual %0d",
                 $time, i, dir_tbl[i].n_fixed, n);
        errors++;
      end
      if (dir_tbl[i].n_fixed > 0 && pending_words[prev_cnt] != dir_tbl[i].first) begin
        $display("%0t table mismatch row %0d: expected %h actual %h",
                 $time, i, dir_tbl[i].first, pending_words[prev_cnt]);
        errors++;
      end
      @(negedge clk_i);
    end
    quiet_in = 0;
    stall_mode = 1;
    // random frames: writes clustered on few rows, then a refresh pass
    for (int f = 0; f < 14; f++) begin
      int nw, base_r;
      base_r = $urandom_range(0, ROWS-1);
      nw = $urandom_range(2, 8);
      for (int k = 0; k < nw; k++) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
          : (base_r + $urandom_range(0, 1)) % ROWS;
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
          : $urandom_range(0, COLS-1);
        send_word(mk(sdre_pkg::KIND_WRITE, r, c, $urandom_range(0, 65535),
                     $urandom_range(0, 1), $urandom_range(0, 7) & ($urandom_range(0, 1) ? 7 : 1),
                     $urandom_range(0, 1) ? 0 : $urandom_range(0, 7),
                     $urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) != 0) send_word(mk(sdre_pkg::KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0));
      for (int k = 0; k < 3; k++) begin
        r = (k == 2) ? $urandom_range(0, 63) : (base_r + k) % ROWS;
        send_word(mk(sdre_pkg::KIND_ROW, r, $urandom_range(0, 127), $urandom_range(0, 65535),
                     0, 0, 0, 0));
      end
      send_word(mk(sdre_pkg::KIND_END, 0, 0, 0, 0, 0, 0, 0));
      if ($urandom_range(0, 9) == 0) begin
        send_word(mk(sdre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      end
      if ($urandom_range(0, 5) == 0) begin
        sdre_pkg::in_word_t junk;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        junk = rnd[$bits(sdre_pkg::in_word_t)-1:0];
        send_word(junk);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // output stall generator
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_mode && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_stall_i <= 1'b1;
          repeat (g) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    sdre_pkg::out_word_t e;
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_word_o);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_word_o != e) begin
          $display("%0t mismatch: expected mv%0b r%0d c%0d sa%0b f%0d b%0d br%0b ch%h hc%0b l%0b",
                   $time, e.move_cursor, e.out_row, e.out_col, e.set_attr, e.out_fore,
                   e.out_back, e.out_bright, e.out_char, e.has_char, e.last_of_run);
          $display("%0t          actual mv%0b r%0d c%0d sa%0b f%0d b%0d br%0b ch%h hc%0b l%0b",
                   $time, out_word_o.move_cursor, out_word_o.out_row, out_word_o.out_col,
                   out_word_o.set_attr, out_word_o.out_fore, out_word_o.out_back,
                   out_word_o.out_bright, out_word_o.out_char, out_word_o.has_char,
                   out_word_o.last_of_run);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
